// ===== rtl/core/rtcac_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcac_pkg
// shared types and codes for the rtc alarm crossing unit
// ----------------------------------------------------------------------------
`default_nettype none

package rtcac_pkg;

    // command codes
    localparam logic [2:0] CMD_OBSERVE    = 3'd0;
    localparam logic [2:0] CMD_SET_ALARM  = 3'd1;
    localparam logic [2:0] CMD_SET_ENABLE = 3'd2;
    localparam logic [2:0] CMD_NOTIFY     = 3'd3;
    localparam logic [2:0] CMD_READ       = 3'd4;
    localparam logic [2:0] CMD_RESET      = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NONE      = 2'd1;
    localparam logic [1:0] ST_TOO_SMALL = 2'd2;

    // bus widths
    localparam int IN_DATA_W  = 152;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 80;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] new_alarm_time;
        logic        enable_value;
        logic [63:0] reading;
        logic [15:0] capacity;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] alarm_time_out;
        logic        enabled_out;
        logic        pending_out;
        logic [7:0]  written_length;
    } t_result;

    typedef struct packed {
        logic [63:0] alarm_target;
        logic [63:0] prior_reading;
        logic        armed;
        logic        alarm_pending;
        logic        reading_seen;
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/rtcac_eval.sv =====
// ----------------------------------------------------------------------------
// rtcac_eval
// next alarm state and result word for one command
// ----------------------------------------------------------------------------
`default_nettype none

module rtcac_eval #(
    parameter int NOTIF_BYTES = 16
) (
    input  wire rtcac_pkg::t_item   i_item,
    input  wire rtcac_pkg::t_state  i_state,
    output rtcac_pkg::t_state       o_state,
    output rtcac_pkg::t_result      o_result
);

    logic w_rd_ge_target;
    logic w_rd_ge_new;
    logic w_prior_lt_target;
    logic w_cap_ok;

    assign w_rd_ge_target    = i_item.reading >= i_state.alarm_target;
    assign w_rd_ge_new       = i_item.reading >= i_item.new_alarm_time;
    assign w_prior_lt_target = i_state.prior_reading < i_state.alarm_target;
    assign w_cap_ok          = i_item.capacity >= 16'(NOTIF_BYTES);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_item.command)
            rtcac_pkg::CMD_OBSERVE: begin
                // armed crossing: reading >= target, prior below or unseen
                if (i_state.armed && w_rd_ge_target &&
                    (!i_state.reading_seen || w_prior_lt_target)) begin
                    o_state.alarm_pending = 1'b1;
                end
                o_state.prior_reading = i_item.reading;
                o_state.reading_seen  = 1'b1;
            end
            rtcac_pkg::CMD_SET_ALARM: begin
                o_state.alarm_target  = i_item.new_alarm_time;
                o_state.armed         = i_item.enable_value;
                o_state.alarm_pending = i_item.enable_value && w_rd_ge_new;
                o_state.prior_reading = i_item.reading;
                o_state.reading_seen  = 1'b1;
            end
            rtcac_pkg::CMD_SET_ENABLE: begin
                o_state.armed = i_item.enable_value;
                if (!i_item.enable_value) begin
                    o_state.alarm_pending = 1'b0;
                end else begin
                    o_state.alarm_pending = w_rd_ge_target;
                    o_state.prior_reading = i_item.reading;
                    o_state.reading_seen  = 1'b1;
                end
            end
            rtcac_pkg::CMD_NOTIFY: begin
                if (!i_state.alarm_pending) begin
                    o_result.status = rtcac_pkg::ST_NONE;
                end else if (!w_cap_ok) begin
                    o_result.status = rtcac_pkg::ST_TOO_SMALL;
                end else begin
                    o_state.alarm_pending   = 1'b0;
                    o_result.written_length = 8'(NOTIF_BYTES);
                end
            end
            rtcac_pkg::CMD_READ: begin
                o_result.alarm_time_out = i_state.alarm_target;
                o_result.enabled_out    = i_state.armed;
            end
            rtcac_pkg::CMD_RESET: begin
                o_state = '0;
            end
            default: begin
                // unused codes leave everything alone
            end
        endcase
        o_result.pending_out = o_state.alarm_pending;
    end

endmodule

`default_nettype wire

// ===== rtl/core/rtc_alarm_crossing_unit_core.sv =====
// ----------------------------------------------------------------------------
// rtc_alarm_crossing_unit_core - alarm comparator for a real-time clock
// path: command word taken into the input register, result word then loaded
// into the result register (compare logic in between)
// throughput: one command per cycle, single compare stage, unless stalled
// reset: synchronous active low, clears both valid flags and all alarm state
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_alarm_crossing_unit_core #(
    parameter int NOTIF_BYTES = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,

    // command stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // new_alarm_time[63:0], enable_value[64], reading[128:65],
    // capacity[144:129], zero pad[151:145]
    input  wire [rtcac_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command[2:0]
    input  wire [rtcac_pkg::IN_USER_W-1:0]  s_axis_tuser,

    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status[1:0], alarm_time_out[65:2], enabled_out[66], pending_out[67],
    // written_length[75:68], zero pad[79:76]
    output logic [rtcac_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // pipeline: input register -> compare/update logic -> result register
    logic                 r_in_valid;
    rtcac_pkg::t_item     r_in;
    logic                 r_out_valid;
    rtcac_pkg::t_result   r_out;
    rtcac_pkg::t_state    r_state;

    rtcac_pkg::t_state    n_state;
    rtcac_pkg::t_result   n_out;
    rtcac_pkg::t_item     w_item;
    logic                 w_advance;

    // result register frees up when empty or being drained this cycle
    assign w_advance     = !r_out_valid || m_axis_tready;
    // input register takes a word when empty or when its word moves on
    assign s_axis_tready = !r_in_valid || w_advance;

    // unpack the command word
    always_comb begin
        w_item.command        = s_axis_tuser;
        w_item.new_alarm_time = s_axis_tdata[63:0];
        w_item.enable_value   = s_axis_tdata[64];
        w_item.reading        = s_axis_tdata[128:65];
        w_item.capacity       = s_axis_tdata[144:129];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= w_item;
        end
    end

    rtcac_eval #(
        .NOTIF_BYTES (NOTIF_BYTES)
    ) u_eval (
        .i_item   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // alarm state moves only when a command leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.written_length, r_out.pending_out,
                            r_out.enabled_out, r_out.alarm_time_out, r_out.status};

endmodule

`default_nettype wire

// ===== rtl/core/rtcac_checker.sv =====
// ----------------------------------------------------------------------------
// rtcac_checker
// port-level checks on the result stream of the alarm crossing unit
// ----------------------------------------------------------------------------
`default_nettype none

module rtcac_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [79:0]  m_axis_tdata
);

    // nothing comes out the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // bytes written only on a clean notification, which clears pending
    a_written_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[75:68] != 8'd0 |->
            m_axis_tdata[1:0] == rtcac_pkg::ST_OK && !m_axis_tdata[67])
        else $error("bytes written without clean notification");

    // failed notification: nothing pending means flag low, too small keeps it
    a_fail_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != rtcac_pkg::ST_OK |->
            m_axis_tdata[75:68] == 8'd0 && m_axis_tdata[65:2] == 64'd0 &&
            (m_axis_tdata[1:0] == rtcac_pkg::ST_NONE) == !m_axis_tdata[67])
        else $error("failed notification result inconsistent");

endmodule

bind rtc_alarm_crossing_unit_core rtcac_checker u_rtcac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
